// ----- rtl/list_merge_sorter_core_defines.svh -----
// Assertion macros used by the list merge sorter core.
`ifndef LIST_MERGE_SORTER_CORE_DEFINES_SVH
`define LIST_MERGE_SORTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define LMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define LMS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LMS_ASSERT(label, clk, rst_n, prop, msg)
`define LMS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/lms_pkg.sv -----
// Types and constants of the list merge sorter.
package lms_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic              keep;
        logic              occ;
        logic [DATA_W-1:0] value;
    } t_link;

    // Broadcast command to every cell.
    typedef struct packed {
        logic              insert;
        logic              shift;
        logic [DATA_W-1:0] value;
    } t_cmd;

endpackage

// ----- rtl/list_merge_sorter_core.sv -----
// List sorter: a chain of MAX_ITEMS insertion cells. Each input transaction is
// placed in sorted position in the cycle it is accepted, so loading runs at one
// value per cycle. A transaction with last set ends the list: input ready drops
// and the chain shifts toward cell 0, giving one result per cycle while the
// output is not stalled, smallest first, until every stored value is out. Values
// beyond MAX_ITEMS are discarded and every result of that list has dropped set.
`include "list_merge_sorter_core_defines.svh"

module list_merge_sorter_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [lms_pkg::DATA_W-1:0] i_value,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [lms_pkg::DATA_W-1:0] o_value_res,
    output logic                       o_last_res,
    output logic                       o_dropped
);

    lms_pkg::t_state           r_state;
    lms_pkg::t_state           n_state;
    logic [lms_pkg::CNT_W-1:0] r_count;
    logic [lms_pkg::CNT_W-1:0] n_count;
    logic                      r_dropped;
    logic                      n_dropped;

    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_full;
    lms_pkg::t_cmd  w_cmd;
    lms_pkg::t_link w_link [lms_pkg::MAX_ITEMS];

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign w_full    = (r_count == lms_pkg::CNT_W'(lms_pkg::MAX_ITEMS));

    assign w_cmd.insert = w_in_acc && !w_full;
    assign w_cmd.shift  = w_out_acc;
    assign w_cmd.value  = i_value;

    for (genvar g = 0; g < lms_pkg::MAX_ITEMS; g++) begin : g_cell
        lms_pkg::t_link w_prev;
        lms_pkg::t_link w_next;

        if (g == 0) begin : g_head
            assign w_prev = '{keep: 1'b1, occ: 1'b0, value: '0};
        end else begin : g_body
            assign w_prev = w_link[g-1];
        end

        if (g == lms_pkg::MAX_ITEMS - 1) begin : g_tail
            assign w_next = '{keep: 1'b0, occ: 1'b0, value: '0};
        end else begin : g_inner
            assign w_next = w_link[g+1];
        end

        lms_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (w_cmd),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_link (w_link[g])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lms_pkg::ST_LOAD: begin
                if (w_in_acc && i_last) begin
                    n_state = lms_pkg::ST_EMIT;
                end
            end
            lms_pkg::ST_EMIT: begin
                if (w_out_acc && o_last_res) begin
                    n_state = lms_pkg::ST_LOAD;
                end
            end
            default: n_state = lms_pkg::ST_LOAD;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            lms_pkg::ST_LOAD: o_ready = 1'b1;
            lms_pkg::ST_EMIT: o_valid = 1'b1;
            default: begin
                o_ready = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_value_res = w_link[0].value;
    assign o_last_res  = (r_count == lms_pkg::CNT_W'(1));
    assign o_dropped   = r_dropped;

    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (w_cmd.insert) begin
            n_count = r_count + lms_pkg::CNT_W'(1);
        end
        if (w_in_acc && w_full) begin
            n_dropped = 1'b1;
        end
        if (w_out_acc) begin
            n_count = r_count - lms_pkg::CNT_W'(1);
            if (o_last_res) begin
                n_dropped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lms_pkg::ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    `LMS_ASSERT(a_emit_nonempty, i_clk, i_rst_n, o_valid |-> (r_count != '0), "emit with empty chain")
    `LMS_ASSERT(a_head_occupied, i_clk, i_rst_n, o_valid |-> w_link[0].occ, "emit from empty head cell")
    `LMS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= lms_pkg::CNT_W'(lms_pkg::MAX_ITEMS), "count above capacity")
    `LMS_ASSERT(a_last_starts_emit, i_clk, i_rst_n, (w_in_acc && i_last) |=> (r_state == lms_pkg::ST_EMIT), "last transaction did not start emission")
    `LMS_ASSERT(a_emit_done, i_clk, i_rst_n, (w_out_acc && o_last_res) |=> ((r_count == '0) && !r_dropped), "run state not cleared after final result")

endmodule

// ----- rtl/lms_cell.sv -----
// One cell of the sorted insertion chain.
module lms_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lms_pkg::t_cmd  i_cmd,
    input  lms_pkg::t_link i_prev,
    input  lms_pkg::t_link i_next,
    output lms_pkg::t_link o_link
);

    logic [lms_pkg::DATA_W-1:0] r_value;
    logic                       r_occ;
    logic [lms_pkg::DATA_W-1:0] n_value;
    logic                       n_occ;
    logic                       w_keep;

    // Cell keeps its entry when it holds a value not above the new one.
    assign w_keep = r_occ && ($signed(r_value) <= $signed(i_cmd.value));

    assign o_link.keep  = w_keep;
    assign o_link.occ   = r_occ;
    assign o_link.value = r_value;

    always_comb begin
        n_value = r_value;
        n_occ   = r_occ;
        priority if (i_cmd.shift) begin
            n_value = i_next.value;
            n_occ   = i_next.occ;
        end else if (i_cmd.insert && !w_keep) begin
            if (i_prev.keep) begin
                n_value = i_cmd.value;
                n_occ   = 1'b1;
            end else begin
                n_value = i_prev.value;
                n_occ   = i_prev.occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

endmodule
